// ===== rtl/core/lkv_pkg.sv =====
// Package for the LRU key-value cache: sizes, the entry type and the miss value.
// No dependencies; imported by every module of the cache.
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_entry;

endpackage

// ===== rtl/core/lkv_cell.sv =====
// One cell of the recency-ordered row: holds one entry and its match flag.
// Depends on lkv_pkg.
module lkv_cell
    import lkv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmp,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic                     i_shift,
    input  t_entry                   i_prev,
    output t_entry                   o_entry,
    output logic                     o_match
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_key;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_shift) begin
                r_valid <= i_prev.valid;
            end
            if (i_cmp) begin
                r_match <= r_valid && (r_key == i_key);
            end
        end
    end

    // take the neighbor's entry when the row advances through this cell
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};
    assign o_match = r_match;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache: row of lkv_cell,
// control and capacity register. Depends on lkv_pkg and lkv_cell.
//
//   channel   handshake                   payload
//   request   i_start, o_busy             i_func, i_key, i_value
//   result    o_done (strobe)             o_hit, o_read_value
//   config    i_cfg_valid, o_cfg_ready    i_cfg_data (cache_capacity)
//
// On a request, the accept edge compares the key against every cell, the
// next edge moves the row (most recent entry in cell 0) on a hit or a put
// and registers the result, shown with o_done, which strobes for gets only.
// o_busy is high for the one cycle between. Reset is synchronous and clears all valid
// flags at once; no clearing pass. The result side cannot stall.
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_func,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_done,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_read_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CAP_W-1:0]         i_cfg_data
);

    logic                     r_busy;
    logic                     r_func;
    logic signed [DATA_W-1:0] r_key;
    logic signed [DATA_W-1:0] r_value;
    logic [CAP_W-1:0]         r_cap;
    logic [CNT_W-1:0]         r_used;
    logic [CNT_W-1:0]         n_used;
    logic                     r_done;
    logic                     r_hit;
    logic signed [DATA_W-1:0] r_read_value;

    t_entry                   w_entry [ENTRIES];
    logic   [ENTRIES-1:0]     w_match;
    logic   [ENTRIES-1:0]     w_shift;
    t_entry                   w_head;
    logic                     w_accept;
    logic                     w_hit;
    logic [IDX_W-1:0]         w_hit_idx;
    logic signed [DATA_W-1:0] w_hit_value;
    logic [CNT_W-1:0]         w_eff_cap;
    logic                     w_has_room;
    logic [IDX_W-1:0]         w_limit;
    logic                     w_move;

    assign w_accept    = i_start && !r_busy;
    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_used <= '0;
            r_cap  <= CAP_W'(ENTRIES);
        end else begin
            r_busy <= w_accept;
            r_done <= r_busy && (r_func == FUNC_GET);
            r_used <= n_used;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_busy) begin
            r_hit        <= w_hit;
            r_read_value <= w_hit ? w_hit_value : MISS_VALUE;
        end
    end

    // at most one cell matches, so OR the index and value of the hit cell
    always_comb begin
        w_hit_idx   = '0;
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_idx   = w_hit_idx | IDX_W'(i);
                w_hit_value = w_hit_value | w_entry[i].value;
            end
        end
    end

    assign w_hit = |w_match;

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            w_eff_cap = CNT_W'(ENTRIES);
        end else begin
            w_eff_cap = CNT_W'(r_cap);
        end
    end

    assign w_has_room = r_used < w_eff_cap;

    // deepest cell that advances: the hit cell, the first free cell, or the
    // least recent cell when the cache is full
    always_comb begin
        n_used = r_used;
        if (w_hit) begin
            w_limit = w_hit_idx;
        end else if (w_has_room) begin
            w_limit = IDX_W'(r_used);
            if (r_busy && r_func == FUNC_PUT) begin
                n_used = r_used + CNT_W'(1);
            end
        end else begin
            w_limit = IDX_W'(r_used - CNT_W'(1));
        end
    end

    assign w_move = r_busy && (w_hit || r_func == FUNC_PUT);

    always_comb begin
        w_head.valid = 1'b1;
        w_head.key   = r_key;
        w_head.value = (r_func == FUNC_PUT) ? r_value : w_hit_value;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        assign w_shift[g] = w_move && (g <= int'(w_limit));

        lkv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmp   (w_accept),
            .i_key   (i_key),
            .i_shift (w_shift[g]),
            .i_prev  ((g == 0) ? w_head : w_entry[(g == 0) ? 0 : g - 1]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;

endmodule
